// ===== design/tpl_pkg.sv =====
// Shared types and constants for the TCP payload locator.
// Used by tpl_frame and tcp_payload_locator_core; no dependencies.
`timescale 1ns / 1ps

package tpl_pkg;

  localparam int MAX_FRAME_LEN = 16383;
  localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);
  // working width for offsets and length compares (at least a byte)
  localparam int CALC_W        = (POS_W > 8) ? POS_W : 8;
  localparam int START_W       = 8;
  localparam int PLEN_W        = 14;

  localparam logic [15:0] TYPE_VLAN    = 16'h8100;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [3:0]  IP_VERSION_4 = 4'd4;
  localparam logic [15:0] FRAG_MASK    = 16'h1fff;

  localparam int ETH_TYPE_HI  = 12;
  localparam int ETH_TYPE_LO  = 13;
  localparam int VLAN_TYPE_HI = 16;
  localparam int VLAN_TYPE_LO = 17;
  localparam int ETH_HDR_LEN  = 14;
  localparam int VLAN_HDR_LEN = 18;
  localparam int MIN_HDR_LEN  = 20;

  typedef enum logic [3:0] {
    RSN_OK,
    RSN_SHORT_ETH,
    RSN_SHORT_VLAN,
    RSN_NOT_IPV4,
    RSN_SHORT_IP,
    RSN_NOT_V4_TCP,
    RSN_FRAGMENT,
    RSN_BAD_IHL,
    RSN_SHORT_TCP,
    RSN_BAD_DOFF,
    RSN_SHORT_TCP_HDR,
    RSN_TOO_LONG
  } tpl_reason_t;

  // one frame byte leaving the input register
  typedef struct packed {
    logic       go;
    logic       eof;
    logic [7:0] data;
  } tpl_beat_t;

  typedef struct packed {
    logic               accepted;
    tpl_reason_t        reason;
    logic [START_W-1:0] payload_start;
    logic [PLEN_W-1:0]  payload_length;
    logic [15:0]        ether_kind;
    logic [31:0]        src_addr;
    logic [31:0]        dst_addr;
    logic [15:0]        src_port;
    logic [15:0]        dst_port;
  } tpl_result_t;

endpackage

// ===== design/tpl_frame.sv =====
// Per-frame header capture and end-of-frame verdict.
// Depends on tpl_pkg.
`timescale 1ns / 1ps

module tpl_frame import tpl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tpl_beat_t   beat,
  output tpl_result_t result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             too_long_r, too_long_nxt;
  logic [15:0]      outer_r, outer_nxt;
  logic [15:0]      inner_r, inner_nxt;
  logic [7:0]       vihl_r, vihl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [15:0]      frag_r, frag_nxt;
  logic [31:0]      src_a_r, src_a_nxt;
  logic [31:0]      dst_a_r, dst_a_nxt;
  logic [15:0]      src_p_r, src_p_nxt;
  logic [15:0]      dst_p_r, dst_p_nxt;
  logic [3:0]       doff_r, doff_nxt;

  logic [CALC_W-1:0] p, ip_ofs, tcp_ofs, r, q;
  logic [4:0]        r5;
  logic [3:0]        q4;

  // capture of the current byte
  always_comb begin
    pos_nxt      = pos_r;
    too_long_nxt = too_long_r;
    outer_nxt    = outer_r;
    inner_nxt    = inner_r;
    vihl_nxt     = vihl_r;
    proto_nxt    = proto_r;
    frag_nxt     = frag_r;
    src_a_nxt    = src_a_r;
    dst_a_nxt    = dst_a_r;
    src_p_nxt    = src_p_r;
    dst_p_nxt    = dst_p_r;
    doff_nxt     = doff_r;

    p       = CALC_W'(pos_r);
    ip_ofs  = (outer_r == TYPE_VLAN) ? CALC_W'(VLAN_HDR_LEN) : CALC_W'(ETH_HDR_LEN);
    tcp_ofs = ip_ofs + CALC_W'({vihl_r[3:0], 2'b00});
    r       = p - ip_ofs;
    q       = p - tcp_ofs;
    r5      = r[4:0];
    q4      = q[3:0];

    if (pos_r >= POS_W'(MAX_FRAME_LEN)) begin
      too_long_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 1'b1;
      if (p == CALC_W'(ETH_TYPE_HI))  outer_nxt[15:8] = beat.data;
      if (p == CALC_W'(ETH_TYPE_LO))  outer_nxt[7:0]  = beat.data;
      if (p == CALC_W'(VLAN_TYPE_HI)) inner_nxt[15:8] = beat.data;
      if (p == CALC_W'(VLAN_TYPE_LO)) inner_nxt[7:0]  = beat.data;

      // IPv4 header fields
      if (p >= ip_ofs && r < CALC_W'(MIN_HDR_LEN)) begin
        case (r5)
          5'd0:    vihl_nxt          = beat.data;
          5'd6:    frag_nxt[15:8]    = beat.data;
          5'd7:    frag_nxt[7:0]     = beat.data;
          5'd9:    proto_nxt         = beat.data;
          5'd12:   src_a_nxt[31:24]  = beat.data;
          5'd13:   src_a_nxt[23:16]  = beat.data;
          5'd14:   src_a_nxt[15:8]   = beat.data;
          5'd15:   src_a_nxt[7:0]    = beat.data;
          5'd16:   dst_a_nxt[31:24]  = beat.data;
          5'd17:   dst_a_nxt[23:16]  = beat.data;
          5'd18:   dst_a_nxt[15:8]   = beat.data;
          5'd19:   dst_a_nxt[7:0]    = beat.data;
          default: ;
        endcase
      end

      // TCP fields; may overlap the IP header when IHL is tiny
      if (p > ip_ofs && p >= tcp_ofs && q < CALC_W'(13)) begin
        case (q4)
          4'd0:    src_p_nxt[15:8] = beat.data;
          4'd1:    src_p_nxt[7:0]  = beat.data;
          4'd2:    dst_p_nxt[15:8] = beat.data;
          4'd3:    dst_p_nxt[7:0]  = beat.data;
          4'd12:   doff_nxt        = beat.data[7:4];
          default: ;
        endcase
      end
    end
  end

  logic              vlan;
  logic [15:0]       eth;
  logic [CALC_W-1:0] len, ofs, ihl4, doff4, tcp_at, pl_at;
  tpl_reason_t       reason;

  // checks in priority order, on the state including this byte
  always_comb begin
    vlan   = (outer_nxt == TYPE_VLAN);
    eth    = vlan ? inner_nxt : outer_nxt;
    len    = CALC_W'(pos_nxt);
    ofs    = vlan ? CALC_W'(VLAN_HDR_LEN) : CALC_W'(ETH_HDR_LEN);
    ihl4   = CALC_W'({vihl_nxt[3:0], 2'b00});
    doff4  = CALC_W'({doff_nxt, 2'b00});
    tcp_at = ofs + ihl4;
    pl_at  = tcp_at + doff4;

    if (too_long_nxt)                                   reason = RSN_TOO_LONG;
    else if (len < CALC_W'(ETH_HDR_LEN))                reason = RSN_SHORT_ETH;
    else if (vlan && len < CALC_W'(VLAN_HDR_LEN))       reason = RSN_SHORT_VLAN;
    else if (eth != TYPE_IPV4)                          reason = RSN_NOT_IPV4;
    else if (len < ofs + CALC_W'(MIN_HDR_LEN))          reason = RSN_SHORT_IP;
    else if (vihl_nxt[7:4] != IP_VERSION_4 || proto_nxt != PROTO_TCP)
                                                        reason = RSN_NOT_V4_TCP;
    else if ((frag_nxt & FRAG_MASK) != 16'h0000)        reason = RSN_FRAGMENT;
    else if (ihl4 < CALC_W'(MIN_HDR_LEN))               reason = RSN_BAD_IHL;
    else if (len < tcp_at + CALC_W'(MIN_HDR_LEN))       reason = RSN_SHORT_TCP;
    else if (doff4 < CALC_W'(MIN_HDR_LEN))              reason = RSN_BAD_DOFF;
    else if (len < pl_at)                               reason = RSN_SHORT_TCP_HDR;
    else                                                reason = RSN_OK;

    result        = '0;
    result.reason = reason;
    if (reason == RSN_OK) begin
      result.accepted       = 1'b1;
      result.payload_start  = START_W'(pl_at);
      result.payload_length = PLEN_W'(len - pl_at);
      result.ether_kind     = eth;
      result.src_addr       = src_a_nxt;
      result.dst_addr       = dst_a_nxt;
      result.src_port       = src_p_nxt;
      result.dst_port       = dst_p_nxt;
    end
  end

  // frame state is wiped after each end beat
  always_ff @(posedge clk) begin
    if (!rst_n || (beat.go && beat.eof)) begin
      pos_r      <= '0;
      too_long_r <= 1'b0;
      outer_r    <= '0;
      inner_r    <= '0;
      vihl_r     <= '0;
      proto_r    <= '0;
      frag_r     <= '0;
      src_a_r    <= '0;
      dst_a_r    <= '0;
      src_p_r    <= '0;
      dst_p_r    <= '0;
      doff_r     <= '0;
    end else if (beat.go) begin
      pos_r      <= pos_nxt;
      too_long_r <= too_long_nxt;
      outer_r    <= outer_nxt;
      inner_r    <= inner_nxt;
      vihl_r     <= vihl_nxt;
      proto_r    <= proto_nxt;
      frag_r     <= frag_nxt;
      src_a_r    <= src_a_nxt;
      dst_a_r    <= dst_a_nxt;
      src_p_r    <= src_p_nxt;
      dst_p_r    <= dst_p_nxt;
      doff_r     <= doff_nxt;
    end
  end

endmodule

// ===== design/tcp_payload_locator_core.sv =====
// TCP payload locator: top level with input and result registers.
// Depends on tpl_pkg and tpl_frame.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (in_*): one frame byte per beat in wire order, with
//   in_end_of_frame high on the last captured byte. A new beat may be
//   given every cycle while in_stall is low.
// - Result channel (out_*): exactly one beat per frame, carrying the
//   verdict (accepted or a reject reason), payload offset and length,
//   ethertype, IPv4 addresses and TCP ports. Rejected frames carry zeros.
// - Result: registered, appearing in the cycle after the end beat is taken.
// - Throughput: one byte per cycle while in_stall is low; the header capture
//   and all checks sit between the input register and the result register.
// - Stall: while a result waits under out_stall, non-final bytes still
//   flow; only a second end beat is held back, raising in_stall.
// - Reset: synchronous, active low; clears the valid flags of both registers
//   and the frame state, so the next byte is byte zero of a new frame.
// - Frames longer than MAX_FRAME_LEN bytes are counted up to that limit,
//   the surplus ignored, and reported as too long.

module tcp_payload_locator_core import tpl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [3:0]         out_reject_reason,
  output logic [START_W-1:0] out_payload_start,
  output logic [PLEN_W-1:0]  out_payload_length,
  output logic [15:0]        out_ether_kind,
  output logic [31:0]        out_source_address,
  output logic [31:0]        out_dest_address,
  output logic [15:0]        out_source_port,
  output logic [15:0]        out_dest_port
);

  logic        beat_vld_r;
  logic        beat_eof_r;
  logic [7:0]  beat_byte_r;
  logic        out_valid_r;
  tpl_result_t res_r;
  tpl_result_t result;
  tpl_beat_t   beat;
  logic        out_free;
  logic        hold;

  assign out_free  = !out_valid_r || !out_stall;
  // an end beat cannot move while the result register is occupied and stalled
  assign hold      = beat_vld_r && beat_eof_r && !out_free;
  assign in_stall  = hold;

  assign beat.go   = beat_vld_r && !hold;
  assign beat.eof  = beat_eof_r;
  assign beat.data = beat_byte_r;

  tpl_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!hold) beat_vld_r <= in_valid;
      if (beat.go && beat_eof_r) out_valid_r <= 1'b1;
      else if (!out_stall)       out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold) begin
      beat_byte_r <= in_data_byte;
      beat_eof_r  <= in_end_of_frame;
    end
    if (beat.go && beat_eof_r) res_r <= result;
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = res_r.accepted;
  assign out_reject_reason  = res_r.reason;
  assign out_payload_start  = res_r.payload_start;
  assign out_payload_length = res_r.payload_length;
  assign out_ether_kind     = res_r.ether_kind;
  assign out_source_address = res_r.src_addr;
  assign out_dest_address   = res_r.dst_addr;
  assign out_source_port    = res_r.src_port;
  assign out_dest_port      = res_r.dst_port;

  a_accept_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_reject_reason == RSN_OK)))
    else $error("accepted flag disagrees with reject reason");

  a_stall_only_on_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (beat_vld_r && beat_eof_r && out_valid_r))
    else $error("input stalled without a held end beat");

  a_min_payload_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |->
      (out_payload_start >= START_W'(ETH_HDR_LEN + 2 * MIN_HDR_LEN)))
    else $error("accepted frame with payload inside minimum headers");

  a_reject_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_payload_length == '0 && out_source_port == '0 && out_dest_address == '0))
    else $error("rejected frame carries nonzero fields");

endmodule
